FILE: src/xml_entity_text_decoder_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the XML entity text decoder.
// Each macro expects clk and arst_n in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef XML_ENTITY_TEXT_DECODER_TOP_ASSERT_SVH
`define XML_ENTITY_TEXT_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define XETD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xetd assertion failed");

// next-cycle implication
`define XETD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xetd assertion failed");

`endif

FILE: src/xetd_pkg.sv
// ---------------------------------------------------------------------------
// xetd_pkg
// Types, codes and the entity name table of the XML entity text decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package xetd_pkg;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_LT      = 2'd1;
	localparam logic [1:0] ERR_AMP     = 2'd2;
	localparam logic [1:0] ERR_UNKNOWN = 2'd3;

	localparam logic [7:0] CHAR_LT   = 8'h3C;
	localparam logic [7:0] CHAR_GT   = 8'h3E;
	localparam logic [7:0] CHAR_AMP  = 8'h26;
	localparam logic [7:0] CHAR_SEMI = 8'h3B;
	localparam logic [7:0] CHAR_APOS = 8'h27;
	localparam logic [7:0] CHAR_QUOT = 8'h22;

	localparam logic [2:0] NAME_MAX = 3'd4;
	localparam logic [2:0] NAME_SAT = 3'd5;

	localparam logic [31:0] NAME_LT   = 32'h0000_6C74;
	localparam logic [31:0] NAME_GT   = 32'h0000_6774;
	localparam logic [31:0] NAME_AMP  = 32'h0061_6D70;
	localparam logic [31:0] NAME_APOS = 32'h6170_6F73;
	localparam logic [31:0] NAME_QUOT = 32'h7175_6F74;

	typedef struct packed {
		logic       has_char;
		logic [7:0] out_char;
		logic [1:0] error_code;
		logic       end_of_string;
	} result_t;

	typedef struct packed {
		logic       found;
		logic [7:0] char_val;
	} lookup_t;

	// exact match on length and bytes
	function automatic lookup_t lookup_name(logic [2:0] name_len, logic [31:0] name_buf);
		lookup_t r;
		r.found    = 1'b0;
		r.char_val = 8'h00;
		case (name_len)
			3'd2: begin
				if (name_buf == NAME_LT) begin
					r.found = 1'b1; r.char_val = CHAR_LT;
				end else if (name_buf == NAME_GT) begin
					r.found = 1'b1; r.char_val = CHAR_GT;
				end
			end
			3'd3: begin
				if (name_buf == NAME_AMP) begin
					r.found = 1'b1; r.char_val = CHAR_AMP;
				end
			end
			3'd4: begin
				if (name_buf == NAME_APOS) begin
					r.found = 1'b1; r.char_val = CHAR_APOS;
				end else if (name_buf == NAME_QUOT) begin
					r.found = 1'b1; r.char_val = CHAR_QUOT;
				end
			end
			default: begin
				r.found = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: src/xetd_decode.sv
// ---------------------------------------------------------------------------
// xetd_decode
// Entity parse state and the per-byte decode logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "xml_entity_text_decoder_top_assert.svh"

module xetd_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       in_byte,
	input  logic             last,
	output xetd_pkg::result_t result
);

	logic        in_entity_q, in_entity_d;
	logic [31:0] name_buf_q, name_buf_d;
	logic [2:0]  name_len_q, name_len_d;
	logic        failed_q, failed_d;
	logic [1:0]  first_err_q, first_err_d;
	xetd_pkg::lookup_t hit;

	assign hit = xetd_pkg::lookup_name(name_len_q, name_buf_q);

	always_comb begin
		in_entity_d = in_entity_q;
		name_buf_d  = name_buf_q;
		name_len_d  = name_len_q;
		failed_d    = failed_q;
		first_err_d = first_err_q;
		result.has_char = 1'b0;
		result.out_char = 8'h00;
		if (!failed_q) begin
			if (in_byte == xetd_pkg::CHAR_LT) begin
				failed_d    = 1'b1;
				first_err_d = xetd_pkg::ERR_LT;
			end else if (in_byte == xetd_pkg::CHAR_AMP) begin
				if (in_entity_q) begin
					failed_d    = 1'b1;
					first_err_d = xetd_pkg::ERR_AMP;
				end else begin
					in_entity_d = 1'b1;
					name_buf_d  = 32'h0;
					name_len_d  = 3'd0;
				end
			end else if (in_entity_q) begin
				if (in_byte == xetd_pkg::CHAR_SEMI) begin
					if (!hit.found) begin
						failed_d    = 1'b1;
						first_err_d = xetd_pkg::ERR_UNKNOWN;
					end else begin
						result.has_char = 1'b1;
						result.out_char = hit.char_val;
						in_entity_d     = 1'b0;
						name_buf_d      = 32'h0;
						name_len_d      = 3'd0;
					end
				end else if (name_len_q < xetd_pkg::NAME_MAX) begin
					name_buf_d = {name_buf_q[23:0], in_byte};
					name_len_d = name_len_q + 3'd1;
				end else begin
					name_len_d = xetd_pkg::NAME_SAT;
				end
			end else begin
				result.has_char = 1'b1;
				result.out_char = in_byte;
			end
			// entity still open at end of string
			if (last && !failed_d && in_entity_d) begin
				failed_d    = 1'b1;
				first_err_d = xetd_pkg::ERR_AMP;
			end
		end
		result.error_code    = failed_d ? first_err_d : xetd_pkg::ERR_NONE;
		result.end_of_string = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_entity_q <= 1'b0;
			name_buf_q  <= 32'h0;
			name_len_q  <= 3'd0;
			failed_q    <= 1'b0;
			first_err_q <= xetd_pkg::ERR_NONE;
		end else if (advance) begin
			if (last) begin
				in_entity_q <= 1'b0;
				name_buf_q  <= 32'h0;
				name_len_q  <= 3'd0;
				failed_q    <= 1'b0;
				first_err_q <= xetd_pkg::ERR_NONE;
			end else begin
				in_entity_q <= in_entity_d;
				name_buf_q  <= name_buf_d;
				name_len_q  <= name_len_d;
				failed_q    <= failed_d;
				first_err_q <= first_err_d;
			end
		end
	end

	`XETD_ASSERT_NXT(a_last_clears, advance && last, !in_entity_q && !failed_q && (name_len_q == 3'd0))
	`XETD_ASSERT_NOW(a_char_no_err, advance && result.has_char, result.error_code == xetd_pkg::ERR_NONE)
	`XETD_ASSERT_NOW(a_len_bound, 1'b1, name_len_q <= xetd_pkg::NAME_SAT)
	`XETD_ASSERT_NXT(a_fail_sticky, failed_q && !(advance && last), failed_q)

endmodule

FILE: src/xetd_out_reg.sv
// ---------------------------------------------------------------------------
// xetd_out_reg
// Result register on the master side of the stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xetd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  xetd_pkg::result_t din,
	output logic              space,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,  // [7:0] out_char
	output logic [2:0]        m_tuser,  // [0] has_char, [2:1] error_code
	output logic              m_tlast
);

	logic              valid_s2;
	xetd_pkg::result_t res_s2;

	// free when empty or when the held request leaves this cycle
	assign space = !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (space) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= din;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.out_char;
	assign m_tuser  = {res_s2.error_code, res_s2.has_char};
	assign m_tlast  = res_s2.end_of_string;

endmodule

FILE: src/xml_entity_text_decoder_top.sv
// ---------------------------------------------------------------------------
// xml_entity_text_decoder_top
// Decodes XML predefined entities in a byte stream and flags the first error.
// ---------------------------------------------------------------------------
// channel  dir  tdata           tuser                    tlast
// s_*      in   [7:0] in_byte   -                        last
// m_*      out  [7:0] out_char  [0] has_char [2:1] err   end_of_string
//
// One request per cycle sustained while the master takes results; one result per request.
// Each byte passes the input register, then is decoded into the result register.
// The decode state updates only when a byte moves from the input register on.
// A stalled master holds the result register; the input register still takes
// one more request, so s_tready drops only when both are full.
// arst_n clears all control and entity state; the last byte also clears the entity state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xml_entity_text_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic [2:0] m_tuser,   // [0] has_char, [2:1] error_code
	output logic       m_tlast
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              space;
	logic              advance;
	xetd_pkg::result_t result;

	assign advance  = valid_s1 && space;
	assign s_tready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	xetd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_byte (byte_s1),
		.last    (last_s1),
		.result  (result)
	);

	xetd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.din      (result),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: bench/xml_entity_text_decoder_top_tb.sv
// ---------------------------------------------------------------------------
// xml_entity_text_decoder_top_tb
// Drives byte strings into the entity decoder and checks every result against
// a local decode of the same bytes: plain pass-through, the five predefined
// entities, the error cases, long output stalls and random idle on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xml_entity_text_decoder_top_tb;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	xml_entity_text_decoder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// decode state mirrored in the bench
	logic        in_ent;
	logic [31:0] name_buf;
	logic [2:0]  name_len;
	logic        failed;
	logic [1:0]  first_err;

	xetd_pkg::result_t decoded_q[$];
	logic [7:0]  text_q[$];
	int          fail_count = 0;
	int          sent_items = 0;
	bit          src_idle_en = 1'b0;
	bit          snk_idle_en = 1'b0;
	bit          hold_req = 1'b0;

	string known_names[5] = '{"lt", "gt", "amp", "apos", "quot"};
	string bad_names[10] = '{"", "l", "ltx", "am", "ampx", "apo", "quo", "quots", "LT", "Gt"};

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// returns {found, char}
	function automatic logic [8:0] entity_char(logic [2:0] len, logic [31:0] nm);
		case ({len, nm})
			{3'd2, xetd_pkg::NAME_LT}:   return {1'b1, xetd_pkg::CHAR_LT};
			{3'd2, xetd_pkg::NAME_GT}:   return {1'b1, xetd_pkg::CHAR_GT};
			{3'd3, xetd_pkg::NAME_AMP}:  return {1'b1, xetd_pkg::CHAR_AMP};
			{3'd4, xetd_pkg::NAME_APOS}: return {1'b1, xetd_pkg::CHAR_APOS};
			{3'd4, xetd_pkg::NAME_QUOT}: return {1'b1, xetd_pkg::CHAR_QUOT};
			default:                     return 9'd0;
		endcase
	endfunction

	task automatic clear_decode();
		in_ent = 1'b0;
		name_buf = '0;
		name_len = '0;
		failed = 1'b0;
		first_err = xetd_pkg::ERR_NONE;
	endtask

	task automatic flag_fault(input logic [1:0] code);
		if (!failed) begin
			failed = 1'b1;
			first_err = code;
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic last);
		xetd_pkg::result_t r;
		logic       emit;
		logic [7:0] ch;
		logic [8:0] hit;
		emit = 1'b0;
		ch = 8'h00;
		if (!failed) begin
			if (b == xetd_pkg::CHAR_LT) begin
				flag_fault(xetd_pkg::ERR_LT);
			end else if (b == xetd_pkg::CHAR_AMP) begin
				if (in_ent) begin
					flag_fault(xetd_pkg::ERR_AMP);
				end else begin
					in_ent = 1'b1;
					name_buf = '0;
					name_len = '0;
				end
			end else if (in_ent) begin
				if (b == xetd_pkg::CHAR_SEMI) begin
					hit = entity_char(name_len, name_buf);
					if (hit[8]) begin
						emit = 1'b1;
						ch = hit[7:0];
						in_ent = 1'b0;
						name_buf = '0;
						name_len = '0;
					end else begin
						flag_fault(xetd_pkg::ERR_UNKNOWN);
					end
				end else if (name_len < xetd_pkg::NAME_MAX) begin
					name_buf = {name_buf[23:0], b};
					name_len = name_len + 3'd1;
				end else begin
					name_len = xetd_pkg::NAME_SAT;
				end
			end else begin
				emit = 1'b1;
				ch = b;
			end
			// entity still open on the last byte
			if (last && !failed && in_ent)
				flag_fault(xetd_pkg::ERR_AMP);
		end
		r.has_char = emit;
		r.out_char = emit ? ch : 8'h00;
		r.error_code = failed ? first_err : xetd_pkg::ERR_NONE;
		r.end_of_string = last;
		decoded_q.push_back(r);
		if (last)
			clear_decode();
	endtask

	// one request; valid stays up across back-to-back sends
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_byte(b, last);
		sent_items++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
		send_text();
	endtask

	task automatic push_name(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic build_text();
		int         pieces;
		int         pick;
		int         n;
		logic [7:0] b;
		pieces = $urandom_range(1, 12);
		for (int p = 0; p < pieces; p++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				b = 8'($urandom_range(0, 255));
				if (b == xetd_pkg::CHAR_LT || b == xetd_pkg::CHAR_AMP)
					b = 8'h41;
				text_q.push_back(b);
			end else if (pick < 75) begin
				text_q.push_back(xetd_pkg::CHAR_AMP);
				push_name(known_names[$urandom_range(0, 4)]);
				text_q.push_back(xetd_pkg::CHAR_SEMI);
			end else if (pick < 88) begin
				text_q.push_back(xetd_pkg::CHAR_AMP);
				if ($urandom_range(0, 1)) begin
					push_name(bad_names[$urandom_range(0, 9)]);
				end else begin
					n = $urandom_range(0, 6);
					repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 4) != 0)
					text_q.push_back(xetd_pkg::CHAR_SEMI);
			end else if (pick < 94) begin
				text_q.push_back(xetd_pkg::CHAR_LT);
			end else begin
				text_q.push_back(xetd_pkg::CHAR_AMP);
			end
		end
	endtask

	task automatic check_field(input string fname, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", fname, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		xetd_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_q.size() == 0) begin
				$error("result with nothing expected: tdata %0h tuser %0h", m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = decoded_q.pop_front();
				check_field("has_char", want.has_char, m_tuser[0]);
				check_field("out_char", want.out_char, m_tdata);
				check_field("error_code", want.error_code, m_tuser[2:1]);
				check_field("end_of_string", want.end_of_string, m_tlast);
			end
		end
	end

	// output side: random stalls, plus a long hold on request
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (40) @(posedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic test_plain_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(xetd_pkg::CHAR_SEMI, 1'b1);   // semicolon outside an entity
	endtask

	task automatic test_entity_then_lt();
		send_str("&amp;<x");          // bytes after '<' are dropped
	endtask

	task automatic test_bad_entities();
		send_str("&&");
		send_str("&;");
		send_str("&abcde;");
		send_str("&quot");            // open at the end
	endtask

	task automatic test_output_hold();
		hold_req = 1'b1;
		for (int i = 0; i < 24; i++)
			text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
		send_text();
	endtask

	task automatic test_random_text();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		while (sent_items < 1750) begin
			build_text();
			send_text();
		end
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		while (sent_items < 2050) begin
			build_text();
			send_text();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		clear_decode();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_bytes();
		test_entity_then_lt();
		test_bad_entities();
		test_output_hold();
		test_random_text();
		s_tvalid <= 1'b0;
		wait (decoded_q.size() == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("xml_entity_text_decoder_top_tb: clean");
		else
			$display("xml_entity_text_decoder_top_tb: errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("xml_entity_text_decoder_top_tb: errors");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/xetd_pkg.sv
src/xetd_decode.sv
src/xetd_out_reg.sv
src/xml_entity_text_decoder_top.sv
bench/xml_entity_text_decoder_top_tb.sv
